@@ rtl/psp_pkg.sv @@
// Shared types and constants for the point-to-segment projection pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package psp_pkg;
  // width of the min_length configuration register
  localparam int ML_W = 31;

  typedef logic [1:0] region_t;

  localparam region_t REG_INTERIOR = 2'd0;
  localparam region_t REG_START    = 2'd1;
  localparam region_t REG_END      = 2'd2;
  localparam region_t REG_DEGEN    = 2'd3;
endpackage
`default_nettype wire

@@ rtl/psp_front.sv @@
// Front end: differences, squares and dot products, sums, then case classification.
// Four register stages. Depends on psp_pkg.
`default_nettype none
module psp_front #(
  parameter int W = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [2:0][W-1:0]      in_p,
  input  wire  [2:0][W-1:0]      in_a,
  input  wire  [2:0][W-1:0]      in_b,
  input  wire  [psp_pkg::ML_W-1:0] min_length,
  output logic                   out_valid,
  input  wire                    out_ready,
  output psp_pkg::region_t       out_region,
  output logic [2:0][W:0]        out_base,
  output logic [2:0][W:0]        out_magd,
  output logic [2:0]             out_neg,
  output logic [2*W+3:0]         out_dotm,
  output logic [2*W+3:0]         out_den
);
  import psp_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int LW = PW + 2;
  localparam int MW = 2 * ML_W;
  localparam int CW = (LW > MW) ? LW : MW;

  logic [4:1] v_r;
  logic [5:1] en;

  // stage 1
  logic [2:0][W-1:0]  p1_r, a1_r, b1_r;
  logic [2:0][DW-1:0] d1_r, e1_r;
  // stage 2
  logic [2:0][W-1:0]  p2_r, a2_r, b2_r;
  logic [2:0][DW-1:0] d2_r;
  logic [2:0][PW-1:0] sq2_r, de2_r;
  logic [MW-1:0]      lim2_r;
  // stage 3
  logic [2:0][W-1:0]  p3_r, a3_r, b3_r;
  logic [2:0][DW-1:0] d3_r;
  logic [LW-1:0]      len3_r;
  logic signed [LW-1:0] dot3_r;
  logic [MW-1:0]      lim3_r;
  // stage 4
  region_t            reg4_r;
  logic [2:0][DW-1:0] base4_r, magd4_r;
  logic [2:0]         neg4_r;
  logic [LW-1:0]      dotm4_r, den4_r;

  logic [2:0][DW-1:0] d1_nxt, e1_nxt;
  logic [2:0][PW-1:0] sq2_nxt, de2_nxt;
  logic [LW-1:0]      len3_nxt;
  logic signed [LW-1:0] dot3_nxt;
  region_t            reg4_nxt;
  logic [2:0][DW-1:0] base4_nxt, magd4_nxt;
  logic [LW-1:0]      dotm4_nxt, den4_nxt;
  logic               degen, before_a, past_b;

  assign en[5]    = out_ready;
  assign en[4]    = !v_r[4] || en[5];
  assign en[3]    = !v_r[3] || en[4];
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign in_ready = en[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = {in_b[i][W-1], in_b[i]} - {in_a[i][W-1], in_a[i]};
      e1_nxt[i] = {in_p[i][W-1], in_p[i]} - {in_a[i][W-1], in_a[i]};
      sq2_nxt[i] = $signed(d1_r[i]) * $signed(d1_r[i]);
      de2_nxt[i] = $signed(d1_r[i]) * $signed(e1_r[i]);
    end
    len3_nxt = LW'(sq2_r[0]) + LW'(sq2_r[1]) + LW'(sq2_r[2]);
    dot3_nxt = $signed(de2_r[0]) + $signed(de2_r[1]) + $signed(de2_r[2]);
  end

  always_comb begin
    degen    = CW'(len3_r) <= CW'(lim3_r);
    before_a = dot3_r[LW-1];
    past_b   = !before_a && (LW'(dot3_r) > len3_r);
    if (degen) begin
      reg4_nxt = REG_DEGEN;
    end else if (before_a) begin
      reg4_nxt = REG_START;
    end else if (past_b) begin
      reg4_nxt = REG_END;
    end else begin
      reg4_nxt = REG_INTERIOR;
    end
    for (int i = 0; i < 3; i++) begin
      case (reg4_nxt)
        REG_DEGEN: base4_nxt[i] = {p3_r[i][W-1], p3_r[i]};
        REG_END:   base4_nxt[i] = {b3_r[i][W-1], b3_r[i]};
        default:   base4_nxt[i] = {a3_r[i][W-1], a3_r[i]};
      endcase
      magd4_nxt[i] = d3_r[i][DW-1] ? (DW'(0) - d3_r[i]) : d3_r[i];
    end
    // outside the interior the divider sees 0 / 1 and passes the base through
    dotm4_nxt = (reg4_nxt == REG_INTERIOR) ? LW'(dot3_r) : '0;
    den4_nxt  = (reg4_nxt == REG_INTERIOR) ? len3_r : LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_r <= in_p;
      a1_r <= in_a;
      b1_r <= in_b;
      d1_r <= d1_nxt;
      e1_r <= e1_nxt;
    end
    if (en[2]) begin
      p2_r   <= p1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      d2_r   <= d1_r;
      sq2_r  <= sq2_nxt;
      de2_r  <= de2_nxt;
      lim2_r <= min_length * min_length;
    end
    if (en[3]) begin
      p3_r   <= p2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      d3_r   <= d2_r;
      len3_r <= len3_nxt;
      dot3_r <= dot3_nxt;
      lim3_r <= lim2_r;
    end
    if (en[4]) begin
      reg4_r  <= reg4_nxt;
      base4_r <= base4_nxt;
      magd4_r <= magd4_nxt;
      neg4_r  <= {d3_r[2][DW-1], d3_r[1][DW-1], d3_r[0][DW-1]};
      dotm4_r <= dotm4_nxt;
      den4_r  <= den4_nxt;
    end
  end

  assign out_valid  = v_r[4];
  assign out_region = reg4_r;
  assign out_base   = base4_r;
  assign out_magd   = magd4_r;
  assign out_neg    = neg4_r;
  assign out_dotm   = dotm4_r;
  assign out_den    = den4_r;
endmodule
`default_nettype wire

@@ rtl/psp_mul.sv @@
// Dividend build: |D| times the dot product, split in two partial products.
// Two register stages. Depends on psp_pkg.
`default_nettype none
module psp_mul #(
  parameter int W = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  psp_pkg::region_t    in_region,
  input  wire  [2:0][W:0]     in_base,
  input  wire  [2:0][W:0]     in_magd,
  input  wire  [2:0]          in_neg,
  input  wire  [2*W+3:0]      in_dotm,
  input  wire  [2*W+3:0]      in_den,
  output logic                out_valid,
  input  wire                 out_ready,
  output psp_pkg::region_t    out_region,
  output logic [2:0][W:0]     out_base,
  output logic [2:0]          out_neg,
  output logic [2*W+3:0]      out_den,
  output logic [2:0][3*W+4:0] out_num
);
  import psp_pkg::*;

  localparam int DW = W + 1;
  localparam int LW = 2 * DW + 2;
  localparam int NW = DW + LW;
  localparam int HL = LW / 2;
  localparam int HH = LW - HL;

  logic [2:1] v_r;
  logic [3:1] en;

  logic [2:0][DW+HL-1:0] pl_r;
  logic [2:0][DW+HH-1:0] ph_r;
  region_t               reg5_r, reg6_r;
  logic [2:0][DW-1:0]    base5_r, base6_r;
  logic [2:0]            neg5_r, neg6_r;
  logic [LW-1:0]         den5_r, den6_r;
  logic [2:0][NW-1:0]    num6_r;
  logic [2:0][NW-1:0]    num6_nxt;

  assign en[3]    = out_ready;
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign in_ready = en[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num6_nxt[i] = NW'(pl_r[i]) + (NW'(ph_r[i]) << HL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= in_magd[i] * in_dotm[HL-1:0];
        ph_r[i] <= in_magd[i] * in_dotm[LW-1:HL];
      end
      reg5_r  <= in_region;
      base5_r <= in_base;
      neg5_r  <= in_neg;
      den5_r  <= in_den;
    end
    if (en[2]) begin
      num6_r  <= num6_nxt;
      reg6_r  <= reg5_r;
      base6_r <= base5_r;
      neg6_r  <= neg5_r;
      den6_r  <= den5_r;
    end
  end

  assign out_valid  = v_r[2];
  assign out_region = reg6_r;
  assign out_base   = base6_r;
  assign out_neg    = neg6_r;
  assign out_den    = den6_r;
  assign out_num    = num6_r;
endmodule
`default_nettype wire

@@ rtl/psp_div.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on psp_pkg.
`default_nettype none
module psp_div #(
  parameter int W = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  psp_pkg::region_t    in_region,
  input  wire  [2:0][W:0]     in_base,
  input  wire  [2:0]          in_neg,
  input  wire  [2*W+3:0]      in_den,
  input  wire  [2:0][3*W+4:0] in_num,
  output logic                out_valid,
  input  wire                 out_ready,
  output psp_pkg::region_t    out_region,
  output logic [2:0][W:0]     out_base,
  output logic [2:0]          out_neg,
  output logic [2:0][W:0]     out_quot,
  output logic [2:0]          out_rnz
);
  import psp_pkg::*;

  localparam int DW = W + 1;
  localparam int LW = 2 * DW + 2;
  localparam int NW = DW + LW;
  localparam int QW = DW;

  logic [QW:1]   v_r;
  logic [QW+1:1] en;

  logic [2:0][NW-1:0] num_r  [1:QW];
  logic [2:0][QW-1:0] quot_r [1:QW];
  logic [2:0][DW-1:0] base_r [1:QW];
  logic [2:0]         neg_r  [1:QW];
  region_t            reg_r  [1:QW];
  logic [LW-1:0]      den_r  [1:QW];

  assign en[QW+1] = out_ready;
  assign in_ready = en[1];

  for (genvar k = 1; k <= QW; k++) begin : g_stg
    localparam int SH = QW - k;
    logic [2:0][NW-1:0] n_src, n_nxt;
    logic [2:0][QW-1:0] q_src, q_nxt;
    logic [2:0][DW-1:0] b_src;
    logic [2:0]         s_src;
    region_t            r_src;
    logic [LW-1:0]      d_src;
    logic               v_src;
    logic [NW-1:0]      trial;
    logic [2:0]         ge;

    if (k == 1) begin : g_first
      assign n_src = in_num;
      assign q_src = '0;
      assign b_src = in_base;
      assign s_src = in_neg;
      assign r_src = in_region;
      assign d_src = in_den;
      assign v_src = in_valid;
    end else begin : g_rest
      assign n_src = num_r[k-1];
      assign q_src = quot_r[k-1];
      assign b_src = base_r[k-1];
      assign s_src = neg_r[k-1];
      assign r_src = reg_r[k-1];
      assign d_src = den_r[k-1];
      assign v_src = v_r[k-1];
    end

    assign trial = NW'(d_src) << SH;
    assign en[k] = !v_r[k] || en[k+1];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = n_src[i] >= trial;
        n_nxt[i] = ge[i] ? (n_src[i] - trial) : n_src[i];
        q_nxt[i] = q_src[i] | (ge[i] ? (QW'(1) << SH) : QW'(0));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        num_r[k]  <= n_nxt;
        quot_r[k] <= q_nxt;
        base_r[k] <= b_src;
        neg_r[k]  <= s_src;
        reg_r[k]  <= r_src;
        den_r[k]  <= d_src;
      end
    end
  end

  assign out_valid  = v_r[QW];
  assign out_region = reg_r[QW];
  assign out_base   = base_r[QW];
  assign out_neg    = neg_r[QW];
  assign out_quot   = quot_r[QW];
  assign out_rnz    = {|num_r[QW][2], |num_r[QW][1], |num_r[QW][0]};
endmodule
`default_nettype wire

@@ rtl/point_segment_projection_top.sv @@
// Closest point on a 3D segment: top level, min_length register and result stage.
// Depends on psp_pkg, psp_front, psp_mul and psp_div.
//
//  channel | ports                          | direction | transfer when
//  --------+--------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready, in_point_*, | into      | in_valid && in_ready
//          | in_start_*, in_end_*           |           |
//  out     | out_valid/out_ready, out_proj_*,| out of    | out_valid && out_ready
//          | out_region                     |           |
//  cfg     | cfg_we, cfg_wdata              | into      | cfg_we
//
// One item enters per cycle while the output is not stalled; the divider takes
// one quotient bit per stage over COORD_WIDTH+1 stages.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and in_ready stays high while any stage is empty.
// Reset (rst_n low, synchronous) drops every item in flight and clears
// min_length to zero.
`default_nettype none
module point_segment_projection_top #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [COORD_WIDTH-1:0] in_point_x,
  input  wire  signed [COORD_WIDTH-1:0] in_point_y,
  input  wire  signed [COORD_WIDTH-1:0] in_point_z,
  input  wire  signed [COORD_WIDTH-1:0] in_start_x,
  input  wire  signed [COORD_WIDTH-1:0] in_start_y,
  input  wire  signed [COORD_WIDTH-1:0] in_start_z,
  input  wire  signed [COORD_WIDTH-1:0] in_end_x,
  input  wire  signed [COORD_WIDTH-1:0] in_end_y,
  input  wire  signed [COORD_WIDTH-1:0] in_end_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_proj_x,
  output logic signed [COORD_WIDTH-1:0] out_proj_y,
  output logic signed [COORD_WIDTH-1:0] out_proj_z,
  output psp_pkg::region_t             out_region,
  input  wire                          cfg_we,
  input  wire  [psp_pkg::ML_W-1:0]     cfg_wdata
);
  import psp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int LW = 2 * DW + 2;
  localparam int NW = DW + LW;
  localparam int SW = DW + 2;

  logic [ML_W-1:0] min_length_r;

  // front -> multiplier
  logic               f_valid, f_ready;
  region_t            f_region;
  logic [2:0][DW-1:0] f_base, f_magd;
  logic [2:0]         f_neg;
  logic [LW-1:0]      f_dotm, f_den;
  // multiplier -> divider
  logic               m_valid, m_ready;
  region_t            m_region;
  logic [2:0][DW-1:0] m_base;
  logic [2:0]         m_neg;
  logic [LW-1:0]      m_den;
  logic [2:0][NW-1:0] m_num;
  // divider -> result stage
  logic               q_valid, q_ready;
  region_t            q_region;
  logic [2:0][DW-1:0] q_base, q_quot;
  logic [2:0]         q_neg, q_rnz;

  logic               out_valid_r;
  logic [2:0][W-1:0]  res_r, res_nxt;
  region_t            region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= '0;
    end else if (cfg_we) begin
      min_length_r <= cfg_wdata;
    end
  end

  psp_front #(.W(W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_p       ({in_point_z, in_point_y, in_point_x}),
    .in_a       ({in_start_z, in_start_y, in_start_x}),
    .in_b       ({in_end_z, in_end_y, in_end_x}),
    .min_length (min_length_r),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_region (f_region),
    .out_base   (f_base),
    .out_magd   (f_magd),
    .out_neg    (f_neg),
    .out_dotm   (f_dotm),
    .out_den    (f_den)
  );

  psp_mul #(.W(W)) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_region  (f_region),
    .in_base    (f_base),
    .in_magd    (f_magd),
    .in_neg     (f_neg),
    .in_dotm    (f_dotm),
    .in_den     (f_den),
    .out_valid  (m_valid),
    .out_ready  (m_ready),
    .out_region (m_region),
    .out_base   (m_base),
    .out_neg    (m_neg),
    .out_den    (m_den),
    .out_num    (m_num)
  );

  psp_div #(.W(W)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (m_valid),
    .in_ready   (m_ready),
    .in_region  (m_region),
    .in_base    (m_base),
    .in_neg     (m_neg),
    .in_den     (m_den),
    .in_num     (m_num),
    .out_valid  (q_valid),
    .out_ready  (q_ready),
    .out_region (q_region),
    .out_base   (q_base),
    .out_neg    (q_neg),
    .out_quot   (q_quot),
    .out_rnz    (q_rnz)
  );

  // Recover A + D*dot/L2 truncated toward zero from the floor quotient of
  // |D|*dot / L2: negate for a negative D (floor pulls one further down when
  // the remainder is non-zero), then step a negative inexact sum back up by one.
  always_comb begin
    logic signed [SW-1:0] b_e [3];
    logic signed [SW-1:0] q_e [3];
    logic signed [SW-1:0] f_e [3];
    logic signed [SW-1:0] s_e [3];
    for (int i = 0; i < 3; i++) begin
      b_e[i] = SW'($signed(q_base[i]));
      q_e[i] = SW'(q_quot[i]);
      f_e[i] = q_neg[i] ? (-q_e[i] - SW'(q_rnz[i])) : q_e[i];
      s_e[i] = b_e[i] + f_e[i];
      if (q_rnz[i] && s_e[i][SW-1]) begin
        s_e[i] = s_e[i] + SW'(1);
      end
      res_nxt[i] = s_e[i][W-1:0];
    end
  end

  // result register: hold while the consumer stalls
  assign q_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      res_r    <= res_nxt;
      region_r <= q_region;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_proj_x = res_r[0];
  assign out_proj_y = res_r[1];
  assign out_proj_z = res_r[2];
  assign out_region = region_r;
endmodule
`default_nettype wire

@@ rtl/psp_checker.sv @@
// Port-level checks for point_segment_projection_top, attached by bind.
// Depends on psp_pkg and the top level's port list.
`default_nettype none
module psp_checker #(
  parameter int W = 32
) (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire  [W-1:0]           out_proj_x,
  input wire  [W-1:0]           out_proj_y,
  input wire  [W-1:0]           out_proj_z,
  input psp_pkg::region_t       out_region
);
  import psp_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_proj_x) && $stable(out_proj_y)
      && $stable(out_proj_z) && $stable(out_region))
    else $error("stalled result changed");

  // reset drops everything in flight
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input back-pressure only when the whole pipe is full and the output stalls
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipe");
endmodule

bind point_segment_projection_top psp_checker #(.W(COORD_WIDTH)) u_psp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_proj_x (out_proj_x),
  .out_proj_y (out_proj_y),
  .out_proj_z (out_proj_z),
  .out_region (out_region)
);
`default_nettype wire

@@ verif/point_segment_projection_top_tb.sv @@
// Testbench for point_segment_projection_top: closest point on a 3D segment.
// Drives random and directed queries with random idling on both channels and checks
// every result against an exact wide-integer projection; depends on psp_pkg and the RTL.
`default_nettype none

class projection_scoreboard;
  typedef struct {
    logic signed [31:0] x, y, z;
    psp_pkg::region_t   region;
  } proj_t;

  proj_t pending[$];
  int    errors;
  int    checked;
  int    region_seen[4];

  // exact projection; 200-bit signed intermediates hold every product
  function void note_query(logic signed [31:0] p[3], logic signed [31:0] a[3],
                           logic signed [31:0] b[3], logic [30:0] min_len);
    logic signed [199:0] d[3], e[3], len2, dot, lim, num, q;
    logic signed [31:0]  res[3];
    psp_pkg::region_t    reg_code;
    proj_t               r;
    len2 = 0;
    dot  = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 200'(b[i]) - 200'(a[i]);
      e[i] = 200'(p[i]) - 200'(a[i]);
      len2 += d[i] * d[i];
      dot  += e[i] * d[i];
    end
    lim = 200'($unsigned(min_len)) * 200'($unsigned(min_len));
    if (len2 <= lim) begin
      reg_code = psp_pkg::REG_DEGEN;
      res = p;
    end else if (dot < 0) begin
      reg_code = psp_pkg::REG_START;
      res = a;
    end else if (dot > len2) begin
      reg_code = psp_pkg::REG_END;
      res = b;
    end else begin
      reg_code = psp_pkg::REG_INTERIOR;
      for (int i = 0; i < 3; i++) begin
        num = 200'(a[i]) * len2 + d[i] * dot;
        // division truncates toward zero
        q = num / len2;
        res[i] = q[31:0];
      end
    end
    r.x = res[0]; r.y = res[1]; r.z = res[2]; r.region = reg_code;
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] x, y, z, psp_pkg::region_t rg);
    proj_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h z=%h region=%0d", $time, x, y, z, rg);
      errors++;
      return;
    end
    w = pending.pop_front();
    checked++;
    region_seen[w.region]++;
    if (x !== w.x) begin
      $display("%0t: proj_x expected %h actual %h", $time, w.x, x);
      errors++;
    end
    if (y !== w.y) begin
      $display("%0t: proj_y expected %h actual %h", $time, w.y, y);
      errors++;
    end
    if (z !== w.z) begin
      $display("%0t: proj_z expected %h actual %h", $time, w.z, z);
      errors++;
    end
    if (rg !== w.region) begin
      $display("%0t: region expected %0d actual %0d", $time, w.region, rg);
      errors++;
    end
  endfunction
endclass

module point_segment_projection_top_tb;
  import psp_pkg::*;

  localparam int LATENCY    = 40;
  localparam int STALL_LIMIT = 2000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic signed [31:0] in_start_x, in_start_y, in_start_z;
  logic signed [31:0] in_end_x, in_end_y, in_end_z;
  logic signed [31:0] out_proj_x, out_proj_y, out_proj_z;
  region_t            out_region;
  logic [ML_W-1:0]    cfg_wdata;

  projection_scoreboard board;
  logic [ML_W-1:0] min_len;
  int  idle_cycles;
  int  sent;
  bit  timed_out;
  bit  rx_no_stall;

  point_segment_projection_top dut (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_point_x, .in_point_y, .in_point_z,
    .in_start_x, .in_start_y, .in_start_z,
    .in_end_x, .in_end_y, .in_end_z,
    .out_valid, .out_ready,
    .out_proj_x, .out_proj_y, .out_proj_z, .out_region,
    .cfg_we, .cfg_wdata
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: sample at the rising edge, change ready at the falling edge.
  initial begin
    int gap;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      gap = rx_no_stall ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
      board.check_result(out_proj_x, out_proj_y, out_proj_z, out_region);
    end
  end

  // Hold the payload until the transfer; valid stays high back to back.
  task automatic send_query(logic signed [31:0] p[3], logic signed [31:0] a[3],
                            logic signed [31:0] b[3], bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1;
    in_point_x <= p[0]; in_point_y <= p[1]; in_point_z <= p[2];
    in_start_x <= a[0]; in_start_y <= a[1]; in_start_z <= a[2];
    in_end_x   <= b[0]; in_end_y   <= b[1]; in_end_z   <= b[2];
    @(posedge clk iff in_ready);
    board.note_query(p, a, b, min_len);
    sent++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then let the latency pass so the block is idle.
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_min_length(logic [ML_W-1:0] v);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we  <= 0;
    min_len  = v;
  endtask

  function automatic logic signed [31:0] rand_coord(int style);
    case (style)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic random_queries(int count);
    logic signed [31:0] p[3], a[3], b[3];
    int style;
    for (int n = 0; n < count; n++) begin
      style = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_coord(style < 3 ? 0 : (style < 6 ? 2 : (style < 9 ? 1 : 3)));
        b[i] = rand_coord(style < 3 ? 0 : (style < 6 ? 2 : (style < 9 ? 1 : 3)));
        p[i] = rand_coord(style < 3 ? 0 : (style < 6 ? 2 : (style < 9 ? 1 : 3)));
      end
      // short segments now and then, to land near min_length
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < 3; i++) b[i] = a[i] + ($signed($urandom_range(0, 64)) - 32);
      end
      // point at one end of the segment
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < 3; i++) p[i] = $urandom_range(0, 1) ? a[i] : b[i];
      end
      send_query(p, a, b, n % 200 < 30);
    end
  endtask

  initial begin
    logic signed [31:0] p[3], a[3], b[3];
    board = new();
    rst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0;
    {in_point_x, in_point_y, in_point_z} = '0;
    {in_start_x, in_start_y, in_start_z} = '0;
    {in_end_x, in_end_y, in_end_z} = '0;
    min_len = '0; idle_cycles = 0; sent = 0; timed_out = 0; rx_no_stall = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: zero-length segment at reset min_length
    a = '{32'sd100, -32'sd5, 32'sd7}; b = a; p = '{32'sd1, 32'sd2, 32'sd3};
    send_query(p, a, b, 0);
    // before start, beyond end, exactly at the end, and in the interior
    a = '{0, 0, 0}; b = '{32'sh0001_0000, 0, 0};
    p = '{-32'sh0000_8000, 32'sd9, 0};      send_query(p, a, b, 0);
    p = '{32'sh0002_0000, 0, 32'sd4};       send_query(p, a, b, 1);
    p = '{32'sh0001_0000, 32'sd77, 0};      send_query(p, a, b, 1);
    p = '{32'sh0000_4000, 32'sd77, -32'sd1}; send_query(p, a, b, 0);
    // truncation toward zero on negative coordinates
    a = '{-32'sd10, -32'sd10, -32'sd10}; b = '{32'sd3, -32'sd7, 32'sd1};
    p = '{32'sd0, -32'sd9, 32'sd5};         send_query(p, a, b, 0);
    // field extremes
    a = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    b = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0}; send_query(p, a, b, 1);
    p = b;                                   send_query(p, a, b, 1);
    p = a;                                   send_query(b, a, b, 0);
    send_query(a, b, a, 0);
    p = '{-1, -1, -1};                       send_query(p, b, a, 0);
    random_queries(300);

    // min_length extremes and midway settings
    write_min_length(31'h7FFF_FFFF);
    a = '{32'sh8000_0000, 0, 0}; b = '{32'sh7FFF_FFFF, 0, 0};
    send_query(a, a, b, 0);
    random_queries(200);
    write_min_length(31'd20);
    random_queries(250);
    write_min_length(31'h0001_0000);
    random_queries(250);

    // hold off until the pipeline is empty, then send with no receiver stalls
    drain();
    rx_no_stall = 1;
    random_queries(100);
    rx_no_stall = 0;
    write_min_length(31'd0);
    random_queries(230);

    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d queries, checked %0d results", sent, board.checked);
    $display("regions interior/start/end/degenerate: %0d/%0d/%0d/%0d",
             board.region_seen[0], board.region_seen[1],
             board.region_seen[2], board.region_seen[3]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
